/* design/cvss_pkg.sv */
// cvss_pkg: shared types, codes and constants of the cv step sequencer
// no dependencies
`timescale 1ns / 1ps

package cvss_pkg;

  localparam int CVSS_STEPS  = 16;
  localparam int CVSS_QDEPTH = 4;

  localparam int CVSS_CFG_IDX_W  = 2;
  localparam int CVSS_CFG_DATA_W = 5;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] QM_NONE  = 2'd0;
  localparam logic [1:0] QM_VOLTS = 2'd1;
  localparam logic [1:0] QM_SEMI  = 2'd2;

  localparam logic [CVSS_CFG_IDX_W-1:0] CFG_MIN_VOLTS    = 2'd0;
  localparam logic [CVSS_CFG_IDX_W-1:0] CFG_MAX_VOLTS    = 2'd1;
  localparam logic [CVSS_CFG_IDX_W-1:0] CFG_LAST_CHANNEL = 2'd2;
  localparam logic [CVSS_CFG_IDX_W-1:0] CFG_QUANT_MODE   = 2'd3;

  localparam logic [12:0] CVSS_FULL_SCALE = 13'd4096;
  localparam logic [15:0] CVSS_HALF_VOLT  = 16'd1536;
  localparam logic [15:0] CVSS_HALF_SEMI  = 16'd128;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  level_index;
    logic [12:0] level_value;
    logic        step_gate;
    logic        reset_gate;
    logic        step_present;
    logic        jump_present;
    logic [11:0] jump_code;
  } cvss_in_t;

  typedef struct packed {
    logic signed [15:0] voltage;
    logic [3:0]         step_index;
    logic               is_read;
  } cvss_out_t;

  typedef struct packed {
    logic signed [4:0] min_volts;
    logic [3:0]        max_volts;
    logic [3:0]        last_channel;
    logic [1:0]        quant_mode;
  } cvss_cfg_t;

  // one queued operation: a table write or a value to emit
  typedef struct packed {
    logic        is_write;
    logic        is_read;
    logic [3:0]  idx;
    logic [12:0] value;
  } cvss_op_t;

endpackage

/* design/cvss_ram.sv */
// cvss_ram: generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cvss_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/cvss_queue.sv */
// cvss_queue: short fifo of operations between front and back
// depends on cvss_pkg
`timescale 1ns / 1ps

module cvss_queue
  import cvss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cvss_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output cvss_op_t head_op
);

  localparam int QAW = $clog2(CVSS_QDEPTH);

  cvss_op_t       ent_r [CVSS_QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full    = (count_r == (QAW+1)'(CVSS_QDEPTH));
  assign empty   = (count_r == '0);
  assign head_op = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

/* design/cvss_front.sv */
// cvss_front: accepts requests, runs the step and gate history, queues work
// depends on cvss_pkg
`timescale 1ns / 1ps

module cvss_front
  import cvss_pkg::*;
#(
  parameter int STEPS = CVSS_STEPS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  cvss_in_t  in_data,
  output logic      in_stall,
  input  cvss_cfg_t cfg,
  input  logic      q_full,
  output logic      push,
  output cvss_op_t  push_op
);

  logic [3:0] cur_step_r, cur_step_nxt;
  logic       prev_sg_r, prev_sg_nxt;
  logic       prev_rg_r, prev_rg_nxt;

  logic       acc;
  logic       is_tick, do_jump, do_step;
  logic       rst_chg, rise;
  logic [3:0] base, next_step, jump_idx;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  assign is_tick = (in_data.action == ACT_TICK);
  assign do_jump = is_tick && in_data.jump_present;
  assign do_step = is_tick && !in_data.jump_present && in_data.step_present;
  assign rst_chg = (in_data.reset_gate != prev_rg_r);
  assign rise    = in_data.step_gate && !prev_sg_r;
  assign base    = rst_chg ? 4'd0 : cur_step_r;

  always_comb begin
    if ((base >= cfg.last_channel) || (32'(base) >= 32'(STEPS - 1))) begin
      next_step = 4'd0;
    end else begin
      next_step = base + 4'd1;
    end
    jump_idx = in_data.jump_code[11:8];
    if (32'(jump_idx) > 32'(STEPS - 1)) begin
      jump_idx = 4'(STEPS - 1);
    end
  end

  always_comb begin
    push_op.is_write = (in_data.action == ACT_WRITE);
    push_op.is_read  = (in_data.action == ACT_READ);
    push_op.value    = (in_data.level_value > CVSS_FULL_SCALE) ? CVSS_FULL_SCALE
                                                               : in_data.level_value;
    if (do_jump) begin
      push_op.idx = jump_idx;
    end else if (do_step) begin
      push_op.idx = next_step;
    end else begin
      push_op.idx = in_data.level_index;
    end
    push = acc && (push_op.is_write || push_op.is_read || do_jump || (do_step && rise));
  end

  always_comb begin
    cur_step_nxt = cur_step_r;
    prev_sg_nxt  = prev_sg_r;
    prev_rg_nxt  = prev_rg_r;
    if (acc && do_step) begin
      cur_step_nxt = base;
      prev_rg_nxt  = in_data.reset_gate;
      prev_sg_nxt  = in_data.step_gate;
      if (rise) begin
        cur_step_nxt = next_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_step_r <= '0;
      prev_sg_r  <= 1'b0;
      prev_rg_r  <= 1'b0;
    end else begin
      cur_step_r <= cur_step_nxt;
      prev_sg_r  <= prev_sg_nxt;
      prev_rg_r  <= prev_rg_nxt;
    end
  end

endmodule

/* design/cvss_back.sv */
// cvss_back: level table, scaling and rounding pipeline, output register
// depends on cvss_pkg and cvss_ram
`timescale 1ns / 1ps

module cvss_back
  import cvss_pkg::*;
#(
  parameter int STEPS = CVSS_STEPS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cvss_cfg_t cfg,
  input  logic      q_empty,
  input  cvss_op_t  head_op,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output cvss_out_t out_data
);

  localparam int AW = $clog2(STEPS);

  logic              en;
  logic              in_range;
  logic [AW-1:0]     addr;
  logic [12:0]       rdata;
  logic [STEPS-1:0]  vld_r, vld_nxt;

  logic              s1_valid_r, s2_valid_r, out_valid_r;
  logic              s1_use_r;
  logic [3:0]        s1_idx_r, s2_idx_r;
  logic              s1_rd_r, s2_rd_r;
  logic [16:0]       prod_r;
  cvss_out_t         out_data_r, out_data_nxt;

  logic signed [5:0] mn6, mx6, diff6;
  logic [12:0]       lvl;
  logic [17:0]       prod;
  logic signed [19:0] nsum, n3;
  logic signed [15:0] r;
  logic              neg;
  logic [15:0]       a16, av, as16, mag;
  logic [9:0]        t11;
  logic [4:0]        q, q3;

  assign en       = !out_valid_r || !out_stall;
  assign pop      = en && !q_empty;
  assign in_range = (32'(head_op.idx) < 32'(STEPS));
  assign addr     = AW'(head_op.idx);

  cvss_ram #(
    .WIDTH(13),
    .DEPTH(STEPS)
  ) u_levels (
    .clk  (clk),
    .we   (pop && head_op.is_write && in_range),
    .waddr(addr),
    .wdata(head_op.value),
    .re   (en),
    .raddr(addr),
    .rdata(rdata)
  );

  // valid bits stand in for the cleared table after reset
  always_comb begin
    vld_nxt = vld_r;
    if (pop && head_op.is_write && in_range) begin
      vld_nxt[addr] = 1'b1;
    end
  end

  // range clamp of the config
  always_comb begin
    mn6 = {cfg.min_volts[4], cfg.min_volts};
    if (mn6 < -6'sd10) begin
      mn6 = -6'sd10;
    end else if (mn6 > 6'sd0) begin
      mn6 = 6'sd0;
    end
    mx6 = {2'b00, cfg.max_volts};
    if (mx6 > 6'sd10) begin
      mx6 = 6'sd10;
    end
    diff6 = mx6 - mn6;
  end

  assign lvl  = s1_use_r ? rdata : 13'd0;
  assign prod = 18'(lvl) * 18'(diff6[4:0]);

  // floor(3 * (min * 4096 + prod) / 4), then rounding half away from zero
  always_comb begin
    nsum = {{2{mn6[5]}}, mn6, 12'b0} + {3'b000, prod_r};
    n3   = nsum + {nsum[18:0], 1'b0};
    r    = n3[17:2];
    neg  = r[15];
    a16  = neg ? 16'(-r) : 16'(r);
    av   = a16 + CVSS_HALF_VOLT;
    // divide by 3072: by 1024 as a shift, then by 3 as a reciprocal multiply
    t11  = 10'(av[15:10]) * 10'd11;
    q    = t11[9:5];
    q3   = q * 5'd3;
    as16 = a16 + CVSS_HALF_SEMI;
    case (cfg.quant_mode)
      QM_VOLTS: mag = {1'b0, q3, 10'b0};
      QM_SEMI:  mag = {as16[15:8], 8'b0};
      default:  mag = a16;
    endcase
    out_data_nxt.voltage    = neg ? -$signed(mag) : $signed(mag);
    out_data_nxt.step_index = s2_idx_r;
    out_data_nxt.is_read    = s2_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (en) begin
        s1_valid_r  <= pop && !head_op.is_write;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_use_r   <= in_range && vld_r[addr];
      s1_idx_r   <= head_op.idx;
      s1_rd_r    <= head_op.is_read;
      prod_r     <= prod[16:0];
      s2_idx_r   <= s1_idx_r;
      s2_rd_r    <= s1_rd_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/cv_step_sequencer.sv */
// cv_step_sequencer: top level, config registers, front, queue and back
// depends on cvss_pkg, cvss_front, cvss_queue, cvss_back
`timescale 1ns / 1ps

// Step sequencer over a table of STEPS slider levels. Each request is a tick
// of the gate inputs, a level write or a channel read; one request is taken
// per clock cycle unless the queue is full, and its result, if any, passes
// the queue, the registered table read, the multiply and rounding stages of
// the back pipeline. A write uses one slot of it like a read. A four-entry
// queue sits between the request side and the pipeline, so a stalled output
// holds back the input only once the queue is full. The table reads as all
// zero after reset with no clearing pass. Config registers are to be written
// by the user only while the block idles; the block does not enforce it.

module cv_step_sequencer
  import cvss_pkg::*;
#(
  parameter int STEPS = CVSS_STEPS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  cvss_in_t                   in_data,
  output logic                       in_stall,
  output logic                       out_valid,
  output cvss_out_t                  out_data,
  input  logic                       out_stall,
  input  logic                       cfg_we,
  input  logic [CVSS_CFG_IDX_W-1:0]  cfg_index,
  input  logic [CVSS_CFG_DATA_W-1:0] cfg_wdata
);

  cvss_cfg_t cfg_r, cfg_nxt;
  logic      push, pop, q_full, q_empty;
  cvss_op_t  push_op, head_op;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_VOLTS:    cfg_nxt.min_volts    = $signed(cfg_wdata[4:0]);
        CFG_MAX_VOLTS:    cfg_nxt.max_volts    = cfg_wdata[3:0];
        CFG_LAST_CHANNEL: cfg_nxt.last_channel = cfg_wdata[3:0];
        CFG_QUANT_MODE:   cfg_nxt.quant_mode   = cfg_wdata[1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_volts    <= -5'sd5;
      cfg_r.max_volts    <= 4'd5;
      cfg_r.last_channel <= 4'd15;
      cfg_r.quant_mode   <= QM_NONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cvss_front #(
    .STEPS(STEPS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_data (in_data),
    .in_stall(in_stall),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  cvss_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .push_op(push_op),
    .full   (q_full),
    .pop    (pop),
    .empty  (q_empty),
    .head_op(head_op)
  );

  cvss_back #(
    .STEPS(STEPS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .head_op  (head_op),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

/* design/cvss_checker.sv */
// cvss_checker: port level assertions for cv_step_sequencer, bound to the top
// depends on cvss_pkg and cv_step_sequencer
`timescale 1ns / 1ps

module cvss_checker
  import cvss_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input cvss_in_t  in_data,
  input logic      in_stall,
  input logic      out_valid,
  input cvss_out_t out_data,
  input logic      out_stall
);

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the pipeline and the queue
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left work in flight");

  // a new result needs rst_n high in each past cycle that the property samples
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3))
    else $error("result too soon after reset");

  // scaled voltage stays inside plus and minus ten volts
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.voltage >= -16'sd30720) && (out_data.voltage <= 16'sd30720))
    else $error("voltage out of range");

endmodule

bind cv_step_sequencer cvss_checker u_cvss_checker (.*);
